// File: design/mt64_pkg.sv
package mt64_pkg;

  localparam int unsigned STATE_WORDS  = 312;
  localparam int unsigned SHIFT_OFFSET = 156;

  localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] SEED_MULT    = 64'd6364136223846793005;
  localparam logic [63:0] DEFAULT_SEED = 64'd5489;
  localparam logic [63:0] HIGH_BITS    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LOW_BITS     = 64'h0000_0000_7FFF_FFFF;

  localparam logic [63:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

  typedef logic [63:0] word_t;

  function automatic word_t temper(input word_t w);
    word_t v;
    v = w;
    v = v ^ ((v >> 29) & TEMPER_MASK_A);
    v = v ^ ((v << 17) & TEMPER_MASK_B);
    v = v ^ ((v << 37) & TEMPER_MASK_C);
    v = v ^ (v >> 43);
    return v;
  endfunction

endpackage

// File: design/mt64_ram.sv
module mt64_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 312,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mt19937_64_generator_core.sv
// 64-bit Mersenne Twister generator (MT19937-64).
// Input channel (in_valid/in_ready): func = 1 reseeds the state store from
// seed and returns nothing; func = 0 draws one tempered 64-bit word.
// Output channel (out_valid/out_ready): one random_value transaction per draw.
// The block works on one transaction at a time; in_ready is high only while
// the sequencer is idle.
// A plain draw reads its word from the store, registers it and then writes the
// tempered value to the output register. A draw that finds the store used up
// first twists all 312 words, each in states TW_A to TW_D. A reseed writes the
// seed word, then forms each later word with the single 32x32 multiplier that
// builds each 64-bit product in three passes. The first draw after reset seeds
// with 5489 first, then twists the store, then draws.
// All store accesses go through a single RAM with one read and one write port.
// Reset returns the sequencer to idle and marks the generator as unseeded;
// the store itself is not cleared.
// A finished result waits in the output register while the receiver stalls;
// the block still accepts the next transaction, and a later draw holds its
// result until the output register is free.
module mt19937_64_generator_core #(
  parameter int unsigned STATE_WORDS  = mt64_pkg::STATE_WORDS,
  parameter int unsigned SHIFT_OFFSET = mt64_pkg::SHIFT_OFFSET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [63:0] seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] random_value
);

  localparam int unsigned AW = $clog2(STATE_WORDS);
  localparam int unsigned PW = $clog2(STATE_WORDS + 2);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SEED_INIT = 4'd1;
  localparam logic [3:0] ST_MUL0      = 4'd2;
  localparam logic [3:0] ST_MUL1      = 4'd3;
  localparam logic [3:0] ST_MUL2      = 4'd4;
  localparam logic [3:0] ST_TW_A      = 4'd5;
  localparam logic [3:0] ST_TW_B      = 4'd6;
  localparam logic [3:0] ST_TW_C      = 4'd7;
  localparam logic [3:0] ST_TW_D      = 4'd8;
  localparam logic [3:0] ST_DRAW_RD   = 4'd9;
  localparam logic [3:0] ST_DRAW_WT   = 4'd10;
  localparam logic [3:0] ST_DRAW_OUT  = 4'd11;

  localparam logic [AW-1:0] LAST_IDX  = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] OFS_IDX   = AW'(SHIFT_OFFSET);
  localparam logic [AW-1:0] BACK_IDX  = AW'(STATE_WORDS - SHIFT_OFFSET);
  localparam logic [PW-1:0] POS_FULL  = PW'(STATE_WORDS);
  localparam logic [PW-1:0] POS_FRESH = PW'(STATE_WORDS + 1);

  logic [3:0]    state;
  logic [PW-1:0] pos;
  logic [AW-1:0] idx;
  logic          draw_pending;
  logic [63:0]   seed_val;
  logic [63:0]   prev;
  logic [63:0]   acc;
  logic [63:0]   ybits;
  logic [63:0]   word_reg;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  logic [63:0]   mix;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   mul_p;
  logic [63:0]   seed_word;
  logic [AW-1:0] idx_nxt;
  logic [AW-1:0] idx_far;
  logic [63:0]   tw_y;
  logic [63:0]   tw_word;
  logic          out_free;

  mt64_ram #(
    .WIDTH(64),
    .DEPTH(STATE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // The seed recurrence multiplies by a 64-bit constant; only the low 64 bits
  // of the product matter, so three 32x32 partial products suffice.
  assign mix = prev ^ (prev >> 62);

  always_comb begin
    case (state)
      ST_MUL1: begin
        mul_a = mix[63:32];
        mul_b = mt64_pkg::SEED_MULT[31:0];
      end
      ST_MUL2: begin
        mul_a = mix[31:0];
        mul_b = mt64_pkg::SEED_MULT[63:32];
      end
      default: begin
        mul_a = mix[31:0];
        mul_b = mt64_pkg::SEED_MULT[31:0];
      end
    endcase
  end

  assign mul_p     = 64'(mul_a) * 64'(mul_b);
  assign seed_word = acc + {mul_p[31:0], 32'd0};

  assign idx_nxt = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign idx_far = (idx < OFS_IDX) ? idx + OFS_IDX : idx - BACK_IDX;

  assign tw_y    = ybits | (ram_rdata & mt64_pkg::LOW_BITS);
  assign tw_word = ram_rdata ^ (ybits >> 1) ^ (ybits[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);

  always_comb begin
    case (state)
      ST_TW_A:    ram_raddr = idx;
      ST_TW_B:    ram_raddr = idx_nxt;
      ST_TW_C:    ram_raddr = idx_far;
      ST_DRAW_RD: ram_raddr = pos[AW-1:0];
      default:    ram_raddr = idx;
    endcase
  end

  always_comb begin
    case (state)
      ST_SEED_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = seed_val;
      end
      ST_MUL2: begin
        ram_we    = 1'b1;
        ram_wdata = seed_word;
      end
      ST_TW_D: begin
        ram_we    = 1'b1;
        ram_wdata = tw_word;
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = tw_word;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          seed_val <= func ? seed : mt64_pkg::DEFAULT_SEED;
        end
      end
      ST_SEED_INIT: prev <= seed_val;
      ST_MUL0:      acc <= mul_p + 64'(idx);
      ST_MUL1:      acc <= acc + {mul_p[31:0], 32'd0};
      ST_MUL2:      prev <= seed_word;
      ST_TW_B:      ybits <= ram_rdata & mt64_pkg::HIGH_BITS;
      ST_TW_C:      ybits <= tw_y;
      ST_DRAW_WT:   word_reg <= ram_rdata;
      ST_DRAW_OUT: begin
        if (out_free) begin
          random_value <= mt64_pkg::temper(word_reg);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pos          <= POS_FRESH;
      idx          <= '0;
      draw_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // In ST_DRAW_OUT a leaving result is replaced by the new one below.
      if (out_valid && out_ready && (state != ST_DRAW_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            idx <= '0;
            if (func) begin
              draw_pending <= 1'b0;
              state        <= ST_SEED_INIT;
            end else if (pos == POS_FRESH) begin
              draw_pending <= 1'b1;
              state        <= ST_SEED_INIT;
            end else if (pos == POS_FULL) begin
              state <= ST_TW_A;
            end else begin
              state <= ST_DRAW_RD;
            end
          end
        end
        ST_SEED_INIT: begin
          idx   <= idx + 1'b1;
          state <= ST_MUL0;
        end
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: begin
          if (idx == LAST_IDX) begin
            pos          <= POS_FULL;
            idx          <= '0;
            draw_pending <= 1'b0;
            state        <= draw_pending ? ST_TW_A : ST_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_MUL0;
          end
        end
        ST_TW_A: state <= ST_TW_B;
        ST_TW_B: state <= ST_TW_C;
        ST_TW_C: state <= ST_TW_D;
        ST_TW_D: begin
          if (idx == LAST_IDX) begin
            pos   <= '0;
            idx   <= '0;
            state <= ST_DRAW_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_TW_A;
          end
        end
        ST_DRAW_RD: state <= ST_DRAW_WT;
        ST_DRAW_WT: state <= ST_DRAW_OUT;
        ST_DRAW_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            pos       <= pos + 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/mt64_checker.sv
module mt64_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] random_value
);

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(random_value))
    else $error("random_value changed while stalled");

  // Only one transaction is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous transaction in progress");

  // A reseed never produces a result.
  a_seed_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func |=> !$rose(out_valid))
    else $error("result appeared after a reseed");

  // A plain draw is never answered in the very next cycle.
  a_draw_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !func |=> !$rose(out_valid))
    else $error("draw result appeared too early");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind mt19937_64_generator_core mt64_checker u_mt64_checker (.*);
